### hdl/button_click_gesture_detector_unit_assert.svh
// Assertion macros used by the gesture detector back end.
`ifndef BUTTON_CLICK_GESTURE_DETECTOR_UNIT_ASSERT_SVH
`define BUTTON_CLICK_GESTURE_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BCGD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BCGD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/bcgd_pkg.sv
// Types, codes and constants of the button gesture detector.
package bcgd_pkg;

	localparam int KEYS_DEF       = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [15:0] LONG_THRESHOLD_RST = 16'd100;
	localparam logic [15:0] DOUBLE_WINDOW_RST  = 16'd30;

	typedef enum logic [2:0] {
		CFG_ACTIVE_LOW  = 3'd0,
		CFG_LONG_EN     = 3'd1,
		CFG_DOUBLE_EN   = 3'd2,
		CFG_LONG_THR    = 3'd3,
		CFG_DOUBLE_WIN  = 3'd4,
		CFG_KEY_COUNT   = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		OP_SCAN = 1'b0,
		OP_ARM  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_PRESS1 = 3'd1,
		MODE_LONG   = 3'd2,
		MODE_REL1   = 3'd3,
		MODE_PRESS2 = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_CLICK  = 2'd1,
		EV_LONG   = 2'd2,
		EV_DOUBLE = 2'd3
	} ev_t;

	typedef struct packed {
		logic [15:0] active_low_mask;
		logic [15:0] long_enable_mask;
		logic [15:0] double_enable_mask;
		logic [15:0] long_threshold;
		logic [15:0] double_window;
		logic [4:0]  key_count;
	} cfg_t;

	typedef struct packed {
		logic       cmd;
		logic [3:0] key_index;
		logic       first_level;
		logic       confirm_level;
	} scan_item_t;

	typedef struct packed {
		logic [3:0] event_key;
		logic [1:0] event_code;
	} result_t;

	// classified item handed from front to back
	typedef struct packed {
		op_t        op;
		logic [3:0] key_index;
		logic       p1;
		logic       p2;
		logic       long_en;
		logic       dbl_en;
	} q_entry_t;

endpackage

### hdl/bcgd_fifo.sv
// Small synchronous queue with registered storage.
module bcgd_fifo #(
	parameter type item_t = logic,
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	output logic  full,
	input  logic  pop,
	output item_t dout,
	output logic  empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### hdl/bcgd_front.sv
// Front end: accepts scan items, drops keys out of use, resolves polarity and enables.
module bcgd_front #(
	parameter int KEYS = bcgd_pkg::KEYS_DEF
) (
	input  bcgd_pkg::cfg_t       cfg,
	input  logic                 push,
	input  bcgd_pkg::scan_item_t item,
	output logic                 full,
	input  logic                 q_full,
	output logic                 q_push,
	output bcgd_pkg::q_entry_t   q_item
);
	import bcgd_pkg::*;

	logic [3:0] key;
	logic       in_range;
	logic       inv;

	assign key      = item.key_index;
	assign in_range = ({1'b0, key} < cfg.key_count) && (32'(key) < 32'(KEYS));
	assign inv      = cfg.active_low_mask[key];

	assign full   = q_full;
	// items for keys out of use are taken and dropped here
	assign q_push = push && !q_full && in_range;

	always_comb begin
		q_item.op        = item.cmd ? OP_ARM : OP_SCAN;
		q_item.key_index = key;
		q_item.p1        = item.first_level ^ inv;
		q_item.p2        = item.confirm_level ^ inv;
		q_item.long_en   = cfg.long_enable_mask[key];
		q_item.dbl_en    = cfg.double_enable_mask[key];
	end

endmodule

### hdl/bcgd_back.sv
// Back end: per-key state memory and gesture machine, one item per cycle while the result queue is not full.
module bcgd_back #(
	parameter int KEYS       = bcgd_pkg::KEYS_DEF,
	parameter int COUNT_BITS = bcgd_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bcgd_pkg::cfg_t     cfg,
	input  logic               q_empty,
	input  bcgd_pkg::q_entry_t q_head,
	output logic               q_pop,
	input  logic               out_full,
	output logic               out_push,
	output bcgd_pkg::result_t  out_item
);
	import bcgd_pkg::*;
	`include "button_click_gesture_detector_unit_assert.svh"

	localparam int KIDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int STW    = 3 + COUNT_BITS + 1;
	localparam int CMP_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	function automatic logic [KIDX_W-1:0] key2addr(input logic [3:0] k);
		logic [KIDX_W+3:0] ext;
		ext = {{KIDX_W{1'b0}}, k};
		return ext[KIDX_W-1:0];
	endfunction

	// state word: {mode, tick count, ignore flag}
	logic [STW-1:0]        mem [KEYS];
	logic [KEYS-1:0]       vld_q;
	logic [STW-1:0]        rd_data_s2;
	logic                  rd_vld_s2;
	q_entry_t              ent_s2;
	logic                  s2_vld_q;

	logic                  lastwr_vld_q;
	logic [3:0]            lastwr_key_q;
	logic [STW-1:0]        lastwr_data_q;

	logic                  adv;
	logic                  ld;
	logic                  commit;
	logic [KIDX_W-1:0]     ra;
	logic [KIDX_W-1:0]     wa;
	logic [STW-1:0]        cur;
	logic [STW-1:0]        nxt;
	mode_t                 cur_mode;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic                  cur_ign;
	mode_t                 mode_n;
	logic [COUNT_BITS-1:0] cnt_n;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  ign_n;
	ev_t                   ev;

	assign adv    = !s2_vld_q || !out_full;
	assign ld     = adv && !q_empty;
	assign q_pop  = ld;
	assign commit = s2_vld_q && !out_full;
	assign ra     = key2addr(q_head.key_index);
	assign wa     = key2addr(ent_s2.key_index);

	always_ff @(posedge clk) begin
		if (commit) begin
			mem[wa] <= nxt;
		end
		if (ld) begin
			rd_data_s2 <= mem[ra];
			ent_s2     <= q_head;
		end
		if (commit) begin
			lastwr_key_q  <= ent_s2.key_index;
			lastwr_data_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q        <= '0;
			rd_vld_s2    <= 1'b0;
			s2_vld_q     <= 1'b0;
			lastwr_vld_q <= 1'b0;
		end else begin
			if (commit) begin
				vld_q[wa]    <= 1'b1;
				lastwr_vld_q <= 1'b1;
			end
			if (ld) begin
				rd_vld_s2 <= vld_q[ra];
			end
			if (adv) begin
				s2_vld_q <= !q_empty;
			end
		end
	end

	// the read was taken before the last write landed: bypass it for the same key
	always_comb begin
		if (lastwr_vld_q && (lastwr_key_q == ent_s2.key_index)) begin
			cur = lastwr_data_q;
		end else if (rd_vld_s2) begin
			cur = rd_data_s2;
		end else begin
			cur = {MODE_IDLE, {COUNT_BITS{1'b0}}, 1'b0};
		end
	end

	assign cur_mode = mode_t'(cur[STW-1 -: 3]);
	assign cur_cnt  = cur[COUNT_BITS:1];
	assign cur_ign  = cur[0];

	always_comb begin
		mode_n  = cur_mode;
		cnt_n   = cur_cnt;
		ign_n   = cur_ign;
		ev      = EV_NONE;
		cnt_inc = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
		case (ent_s2.op)
			OP_ARM: begin
				ign_n = 1'b1;
			end
			OP_SCAN: begin
				cnt_n = cnt_inc;
				case (cur_mode)
					MODE_IDLE: begin
						if (ent_s2.p1 && ent_s2.p2) begin
							cnt_n  = '0;
							mode_n = MODE_PRESS1;
						end
					end
					MODE_PRESS1: begin
						if (!ent_s2.p1) begin
							if (!ent_s2.p2) begin
								cnt_n = '0;
								if (ent_s2.dbl_en) begin
									mode_n = MODE_REL1;
								end else begin
									mode_n = MODE_IDLE;
									ev     = EV_CLICK;
								end
							end
						end else if (ent_s2.long_en &&
							(CMP_W'(cnt_inc) >= CMP_W'(cfg.long_threshold))) begin
							cnt_n  = '0;
							mode_n = MODE_LONG;
							ev     = EV_LONG;
						end
					end
					MODE_LONG: begin
						if (!ent_s2.p1 && !ent_s2.p2) begin
							cnt_n  = '0;
							mode_n = MODE_IDLE;
						end
					end
					MODE_REL1: begin
						if (ent_s2.p1 && ent_s2.p2) begin
							cnt_n  = '0;
							mode_n = MODE_PRESS2;
						end
						// timeout sees the count after the second-press check
						if (CMP_W'(cnt_n) >= CMP_W'(cfg.double_window)) begin
							cnt_n  = '0;
							mode_n = MODE_IDLE;
							ev     = EV_CLICK;
						end
					end
					MODE_PRESS2: begin
						if (!ent_s2.p1 && !ent_s2.p2) begin
							cnt_n  = '0;
							mode_n = MODE_IDLE;
							ev     = EV_DOUBLE;
						end
					end
					default: begin
					end
				endcase
				if ((ev != EV_NONE) && cur_ign) begin
					ign_n = 1'b0;
					ev    = EV_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	assign nxt                 = {mode_n, cnt_n, ign_n};
	assign out_push            = commit && (ev != EV_NONE);
	assign out_item.event_key  = ent_s2.key_index;
	assign out_item.event_code = ev;

	`BCGD_ASSERT_NOW(a_no_commit_when_full, s2_vld_q && out_full, !commit && !out_push,
		"back end committed while output queue full")
	`BCGD_ASSERT_NOW(a_arm_silent, commit && (ent_s2.op == OP_ARM), !out_push,
		"arm item produced an event")
	`BCGD_ASSERT_NOW(a_event_coded, out_push, out_item.event_code != EV_NONE,
		"event pushed with no code")
	`BCGD_ASSERT_NEXT(a_bypass_tracks_write, commit,
		lastwr_vld_q && (lastwr_key_q == $past(ent_s2.key_index)),
		"bypass register missed the last write")

endmodule

### hdl/button_click_gesture_detector_unit.sv
// Top level of the button gesture detector: config registers, front, queues, back.
//
// Input: one scan item per accepted push (push high, full low). cmd 0 carries two
// samples of a key's pin (scan and debounced re-read); cmd 1 arms the key's
// ignore-next-event flag. Items for keys at or above key_count are dropped.
// Results: click, long press or double click events, oldest on result while
// empty is low, taken by pop. At most one result per item.
// Config: cfg_valid/cfg_ready (ready always high), cfg_index selects the
// register; write only while no item is in flight. Unknown indices are ignored.
// Path: item queue, back end read stage, result queue. Throughput: one item per
// cycle while the result queue is not full, set by the single read and write port
// of the per-key state memory; a same-key item on the next cycle uses a bypass.
// Reset: every key idle, counts and ignore flags clear via per-key valid bits,
// registers at their defaults; no clearing pass, items accepted at once.
// Stall: a 2-entry result queue absorbs short stalls; when it fills the back
// end holds, the 2-entry item queue fills and full rises.
module button_click_gesture_detector_unit #(
	parameter int KEYS        = bcgd_pkg::KEYS_DEF,
	parameter int COUNT_BITS  = bcgd_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = bcgd_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bcgd_pkg::scan_item_t item,
	output logic                 full,
	input  logic                 pop,
	output bcgd_pkg::result_t    result,
	output logic                 empty,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data
);
	import bcgd_pkg::*;

	cfg_t     cfg_q;
	logic     q_full;
	logic     q_push;
	q_entry_t q_in;
	logic     q_empty;
	logic     q_pop;
	q_entry_t q_head;
	logic     out_full;
	logic     out_push;
	result_t  out_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low_mask    <= '0;
			cfg_q.long_enable_mask   <= '0;
			cfg_q.double_enable_mask <= '0;
			cfg_q.long_threshold     <= LONG_THRESHOLD_RST;
			cfg_q.double_window      <= DOUBLE_WINDOW_RST;
			cfg_q.key_count          <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ACTIVE_LOW: cfg_q.active_low_mask    <= cfg_data;
				CFG_LONG_EN:    cfg_q.long_enable_mask   <= cfg_data;
				CFG_DOUBLE_EN:  cfg_q.double_enable_mask <= cfg_data;
				CFG_LONG_THR:   cfg_q.long_threshold     <= cfg_data;
				CFG_DOUBLE_WIN: cfg_q.double_window      <= cfg_data;
				CFG_KEY_COUNT:  cfg_q.key_count          <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	bcgd_front #(
		.KEYS(KEYS)
	) u_front (
		.cfg    (cfg_q),
		.push   (push),
		.item   (item),
		.full   (full),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_in)
	);

	bcgd_fifo #(
		.item_t(q_entry_t),
		.DEPTH (QUEUE_DEPTH)
	) u_item_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_in),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_head),
		.empty (q_empty)
	);

	bcgd_back #(
		.KEYS      (KEYS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.out_full(out_full),
		.out_push(out_push),
		.out_item(out_item)
	);

	bcgd_fifo #(
		.item_t(result_t),
		.DEPTH (QUEUE_DEPTH)
	) u_result_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.din   (out_item),
		.full  (out_full),
		.pop   (pop),
		.dout  (result),
		.empty (empty)
	);

endmodule
